### src/tick_priority_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tick priority task scheduler
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TICK_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define TICK_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tick priority task scheduler check failed");
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tick priority task scheduler check failed");
`else
`define TPS_ASSERT(lbl, prop)
`define TPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/tpts_pkg.sv
// ----------------------------------------------------------------------------
// tpts_pkg
// Request and status codes, field widths and the types shared by the
// scheduler top level and its slot cells.
// ----------------------------------------------------------------------------
package tpts_pkg;

	localparam int SLOT_W = 4;
	localparam int TIME_W = 16;
	localparam int REM_W  = 32;
	localparam int CNT_W  = 5;

	localparam logic [REM_W-1:0] REM_MAX = 32'h7FFF_FFFF;
	localparam logic [REM_W-1:0] REM_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		REQ_TICK     = 3'd0,
		REQ_DISPATCH = 3'd1,
		REQ_ADD      = 3'd2,
		REQ_REMOVE   = 3'd3,
		REQ_PAUSE    = 3'd4,
		REQ_RESUME   = 3'd5,
		REQ_DELAY    = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TAKEN    = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NONE_DUE = 2'd3
	} status_t;

	// request broadcast to every cell
	typedef struct packed {
		req_t              req;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] start_delay;
		logic              one_shot;
		logic [TIME_W-1:0] delay_ticks;
	} cmd_t;

	// per-cell status back to the top level
	typedef struct packed {
		logic occ;
		logic sel;
		logic win;
		logic once;
	} cell_stat_t;

endpackage

### src/tick_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// tick_priority_task_scheduler
// Priority task table built as a row of slot cells with a dispatch claim
// chain; one result transaction per request transaction.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low. Every slot cell updates
// in the cycle the request is accepted, and the dispatch winner is resolved
// in that same cycle by a claim chain running from slot 0 down the row of
// cells. The result is captured in an output register on acceptance; in_stall
// is high only while that register holds a result and out_stall is high.
// No clearing pass follows reset.
`include "tick_priority_task_scheduler_defines.svh"

module tick_priority_task_scheduler
	import tpts_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [SLOT_W-1:0] slot,
	input  logic [TIME_W-1:0] period,
	input  logic [TIME_W-1:0] start_delay,
	input  logic              one_shot,
	input  logic [TIME_W-1:0] delay_ticks,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic              run_valid,
	output logic [SLOT_W-1:0] run_slot,
	output logic [CNT_W-1:0]  task_count
);

	cmd_t              cmd;
	logic              acc;
	logic [NUM_SLOTS:0] claim;
	cell_stat_t        stat [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] occ_vec;
	logic [NUM_SLOTS-1:0] sel_vec;
	logic [NUM_SLOTS-1:0] win_vec;
	logic [NUM_SLOTS-1:0] once_vec;

	logic              sel_any;
	logic              hit_any;
	logic              win_any;
	logic              free_any;
	logic [SLOT_W-1:0] enc;

	status_t           st_d;
	logic              rv_d;
	logic [SLOT_W-1:0] rs_d;
	logic [CNT_W-1:0]  cnt_d;

	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	status_t           status_q;
	logic              run_valid_q;
	logic [SLOT_W-1:0] run_slot_q;
	logic [CNT_W-1:0]  task_count_q;

	assign in_stall = out_valid_q & out_stall;
	assign acc      = in_valid & ~in_stall;

	assign cmd.req         = req_t'(req_type);
	assign cmd.slot        = slot;
	assign cmd.period      = period;
	assign cmd.start_delay = start_delay;
	assign cmd.one_shot    = one_shot;
	assign cmd.delay_ticks = delay_ticks;

	assign claim[0] = 1'b0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		tpts_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.acc      (acc),
			.cmd      (cmd),
			.claim_in (claim[i]),
			.claim_out(claim[i+1]),
			.stat     (stat[i])
		);
		assign occ_vec[i]  = stat[i].occ;
		assign sel_vec[i]  = stat[i].sel;
		assign win_vec[i]  = stat[i].win;
		assign once_vec[i] = stat[i].once;
	end

	assign sel_any  = |sel_vec;
	assign hit_any  = |(sel_vec & occ_vec);
	assign win_any  = claim[NUM_SLOTS];
	assign free_any = |(win_vec & once_vec);

	always_comb begin
		enc = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (win_vec[i]) enc = enc | SLOT_W'(i);
		end
	end

	always_comb begin
		st_d  = ST_OK;
		rv_d  = 1'b0;
		rs_d  = '0;
		cnt_d = count_q;
		case (cmd.req) inside
			REQ_DISPATCH: begin
				if (win_any) begin
					rv_d = 1'b1;
					rs_d = enc;
					if (free_any) cnt_d = count_q - 1'b1;
				end else begin
					st_d = ST_NONE_DUE;
				end
			end
			REQ_ADD: begin
				if (!sel_any) begin
					st_d = ST_EMPTY;
				end else if (hit_any) begin
					st_d = ST_TAKEN;
				end else begin
					cnt_d = count_q + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (!hit_any) st_d = ST_EMPTY;
				else cnt_d = count_q - 1'b1;
			end
			REQ_PAUSE, REQ_RESUME, REQ_DELAY: begin
				if (!hit_any) st_d = ST_EMPTY;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (acc) begin
			count_q     <= cnt_d;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q     <= st_d;
			run_valid_q  <= rv_d;
			run_slot_q   <= rs_d;
			task_count_q <= cnt_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign run_valid  = run_valid_q;
	assign run_slot   = run_slot_q;
	assign task_count = task_count_q;

	`TPS_ASSERT(a_count_matches_occ, count_q == CNT_W'($countones(occ_vec)))
	`TPS_ASSERT(a_single_winner, $onehot0(win_vec))
	`TPS_ASSERT(a_run_means_ok, (out_valid_q && run_valid_q) |-> (status_q == ST_OK))
	`TPS_ASSERT_NEXT(a_none_due, acc && cmd.req == REQ_DISPATCH && !win_any, status_q == ST_NONE_DUE && !run_valid_q)

endmodule

### src/tpts_cell.sv
// ----------------------------------------------------------------------------
// tpts_cell
// One task slot: flags, period and saturating remaining time. Takes the
// dispatch claim from the higher-priority neighbor and passes it on.
// ----------------------------------------------------------------------------
module tpts_cell
	import tpts_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  cmd_t       cmd,
	input  logic       claim_in,
	output logic       claim_out,
	output cell_stat_t stat
);

	logic              occ_q;
	logic              paused_q;
	logic              ready_q;
	logic              one_shot_q;
	logic [TIME_W-1:0] period_q;
	logic [REM_W-1:0]  rem_q;

	logic              sel;
	logic              le0;
	logic              elig;
	logic              win;
	logic [REM_W+1:0]  opa;
	logic [REM_W+1:0]  opb;
	logic [REM_W+1:0]  sum;
	logic [REM_W-1:0]  sat;
	logic              new_le0;

	assign sel       = (int'(cmd.slot) == IDX);
	assign le0       = rem_q[REM_W-1] | (rem_q == '0);
	assign elig      = occ_q & ~paused_q & ready_q & le0;
	assign win       = elig & ~claim_in;
	assign claim_out = claim_in | elig;

	assign stat.occ  = occ_q;
	assign stat.sel  = sel;
	assign stat.win  = win;
	assign stat.once = one_shot_q;

	// single saturating adder shared by all requests
	always_comb begin
		opa = {{2{rem_q[REM_W-1]}}, rem_q};
		opb = '0;
		case (cmd.req)
			REQ_TICK:     opb = '1;
			REQ_DISPATCH: opb = (REM_W+2)'(period_q);
			REQ_ADD: begin
				opa = (REM_W+2)'(cmd.period);
				opb = (REM_W+2)'(cmd.start_delay);
			end
			REQ_DELAY:    opb = (REM_W+2)'(cmd.delay_ticks);
			default:      opb = '0;
		endcase
		sum = opa + opb;
		if (sum[REM_W+1:REM_W-1] == 3'b000 || sum[REM_W+1:REM_W-1] == 3'b111) begin
			sat = sum[REM_W-1:0];
		end else if (sum[REM_W+1]) begin
			sat = REM_MIN;
		end else begin
			sat = REM_MAX;
		end
	end

	assign new_le0 = sat[REM_W-1] | (sat == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= 1'b0;
			paused_q <= 1'b0;
			ready_q  <= 1'b0;
		end else if (acc) begin
			case (cmd.req)
				REQ_TICK: begin
					if (occ_q && !paused_q && new_le0) ready_q <= 1'b1;
				end
				REQ_DISPATCH: begin
					if (win) begin
						ready_q <= 1'b0;
						if (one_shot_q) begin
							occ_q    <= 1'b0;
							paused_q <= 1'b0;
						end
					end
				end
				REQ_ADD: begin
					if (sel && !occ_q) begin
						occ_q    <= 1'b1;
						paused_q <= 1'b0;
						ready_q  <= 1'b1;
					end
				end
				REQ_REMOVE: begin
					if (sel && occ_q) begin
						occ_q    <= 1'b0;
						paused_q <= 1'b0;
						ready_q  <= 1'b0;
					end
				end
				REQ_PAUSE: begin
					if (sel && occ_q) paused_q <= 1'b1;
				end
				REQ_RESUME: begin
					if (sel && occ_q) paused_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			case (cmd.req)
				REQ_TICK: begin
					if (occ_q && !paused_q) rem_q <= sat;
				end
				REQ_DISPATCH: begin
					if (win && !one_shot_q) rem_q <= sat;
				end
				REQ_ADD: begin
					if (sel && !occ_q) begin
						rem_q      <= sat;
						period_q   <= cmd.period;
						one_shot_q <= cmd.one_shot;
					end
				end
				REQ_DELAY: begin
					if (sel && occ_q) rem_q <= sat;
				end
				default: ;
			endcase
		end
	end

endmodule
